// ===== sv/tvfx_pkg.sv =====
// Shared types and constants for the tracker voice effect engine.
`timescale 1ns / 1ps
package tvfx_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Effect codes
  localparam logic [2:0] FX_NONE     = 3'd0;
  localparam logic [2:0] FX_SLIDE    = 3'd1;
  localparam logic [2:0] FX_VIBRATO  = 3'd2;
  localparam logic [2:0] FX_DROP     = 3'd3;
  localparam logic [2:0] FX_FADE_IN  = 3'd4;
  localparam logic [2:0] FX_FADE_OUT = 3'd5;
  localparam logic [2:0] FX_ARP_FAST = 3'd6;
  localparam logic [2:0] FX_ARP_SLOW = 3'd7;

  // Field widths
  localparam int unsigned VoiceW = 3;
  localparam int unsigned NoteW  = 14;
  localparam int unsigned PitchW = 16;
  localparam int unsigned VolW   = 7;
  localparam int unsigned LenW   = 8;

  // Serial multiply-divide unit: a (16) * b (8) / d (8)
  localparam int unsigned MdAW   = PitchW;
  localparam int unsigned MdBW   = LenW;
  localparam int unsigned MdProdW = MdAW + MdBW;

  // Volume scaling
  localparam logic [9:0] VOL_SCALE = 10'd73;
  localparam logic [VolW-1:0] VOL_MAX = 7'd127;

  // Arpeggio toggle bits of the elapsed count
  localparam int unsigned ArpFastBit = 3;
  localparam int unsigned ArpSlowBit = 4;
  localparam int unsigned VibShift   = 6;

endpackage

// ===== sv/tvfx_muldiv.sv =====
// Bit-serial multiply then restoring divide: q = (a * b) / d.
`timescale 1ns / 1ps
module tvfx_muldiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tvfx_pkg::MdAW-1:0] a_i,
  input  logic [tvfx_pkg::MdBW-1:0] b_i,
  input  logic [tvfx_pkg::MdBW-1:0] d_i,
  output logic                      done_o,
  output logic [tvfx_pkg::MdAW-1:0] q_o
);
  import tvfx_pkg::*;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_st_e;

  localparam int unsigned CntW = $clog2(MdProdW);

  md_st_e               st_q;
  logic [CntW-1:0]      cnt_q;
  logic [MdAW-1:0]      a_q;
  logic [MdBW-1:0]      b_q;
  logic [MdBW-1:0]      d_q;
  logic [MdProdW-1:0]   acc_q;
  logic [MdBW-1:0]      rem_q;
  logic                 done_q;

  logic [MdBW:0]        rem_sh;
  logic                 ge;
  logic [MdBW:0]        rem_sub;

  // One divide step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, acc_q[MdProdW-1]};
    ge      = rem_sh >= {1'b0, d_q};
    rem_sub = rem_sh - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        MD_IDLE: begin
          if (start_i) begin
            a_q   <= a_i;
            b_q   <= b_i;
            d_q   <= d_i;
            acc_q <= '0;
            rem_q <= '0;
            cnt_q <= '0;
            st_q  <= MD_MUL;
          end
        end
        // Multiply, multiplier msb first: one bit a cycle
        MD_MUL: begin
          acc_q <= {acc_q[MdProdW-2:0], 1'b0} + (b_q[MdBW-1] ? MdProdW'(a_q) : '0);
          b_q   <= {b_q[MdBW-2:0], 1'b0};
          if (cnt_q == CntW'(MdBW - 1)) begin
            cnt_q <= '0;
            st_q  <= MD_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        // Divide: one quotient bit a cycle, shifted into the dividend
        MD_DIV: begin
          rem_q <= ge ? rem_sub[MdBW-1:0] : rem_sh[MdBW-1:0];
          acc_q <= {acc_q[MdProdW-2:0], ge};
          if (cnt_q == CntW'(MdProdW - 1)) begin
            done_q <= 1'b1;
            st_q   <= MD_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: st_q <= MD_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o    = acc_q[MdAW-1:0];

endmodule

// ===== sv/tracker_voice_effect_engine_top.sv =====
// Top level of the per-voice note effect engine.
//
//  channel | direction | handshake                  | beat
//  in      | input     | in_valid_i / in_ready_o    | cmd, voice, pitch, volume, effect, length
//  out     | output    | out_valid_o / out_ready_i  | voice, pitch write, volume write
//
// One beat at a time. Start, stop and plain ticks go from accept through the evaluate
// and done states to output valid. Drop, fades and a slide in progress run the bit-serial
// multiply-divide unit, multiply then divide, between the evaluate and done states.
// Reset clears every voice to inactive with zeroed state; no clearing pass.
// A stalled output holds; the next beat is accepted while it waits.
`timescale 1ns / 1ps
module tracker_voice_effect_engine_top #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [tvfx_pkg::VoiceW-1:0]   voice_i,
  input  logic [tvfx_pkg::NoteW-1:0]    note_pitch_i,
  input  logic [2:0]                    note_volume_i,
  input  logic [2:0]                    effect_code_i,
  input  logic [tvfx_pkg::LenW-1:0]     length_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvfx_pkg::VoiceW-1:0]   out_voice_o,
  output logic                          pitch_valid_o,
  output logic [tvfx_pkg::NoteW-1:0]    pitch_out_o,
  output logic                          volume_valid_o,
  output logic [tvfx_pkg::VolW-1:0]     volume_out_o
);
  import tvfx_pkg::*;

  localparam int unsigned VIdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_MD, ST_DONE} st_e;
  typedef enum logic [1:0] {MD_DROP, MD_UP, MD_DN, MD_VOL} md_mode_e;

  st_e                 st_q;
  md_mode_e            md_mode_q, md_mode_d;

  // Latched input beat
  logic [1:0]          cmd_q;
  logic [VoiceW-1:0]   voice_q;
  logic [NoteW-1:0]    np_q;
  logic [2:0]          nv_q;
  logic [2:0]          eff_q;
  logic [LenW-1:0]     len_q;

  // Per-voice state
  logic [PitchW-1:0]   base_pitch_q   [NUM_VOICES];
  logic [PitchW-1:0]   target_pitch_q [NUM_VOICES];
  logic [VolW-1:0]     base_volume_q  [NUM_VOICES];
  logic [LenW-1:0]     note_length_q  [NUM_VOICES];
  logic [PitchW-1:0]   elapsed_q      [NUM_VOICES];
  logic [2:0]          effect_kind_q  [NUM_VOICES];
  logic [NUM_VOICES-1:0] active_q;

  // Pending result
  logic                res_pv_q, res_pv_d;
  logic                res_vv_q, res_vv_d;
  logic [PitchW-1:0]   res_p_q, res_p_d;
  logic [VolW-1:0]     res_vol_q, res_vol_d;

  // Output register
  logic                out_valid_q;
  logic [VoiceW-1:0]   out_voice_q;
  logic                out_pv_q, out_vv_q;
  logic [NoteW-1:0]    out_p_q;
  logic [VolW-1:0]     out_vol_q;

  // Voice state write strobes
  logic                wr_base, wr_tgt, wr_vol, wr_note, wr_el, wr_act, act_new;
  logic [PitchW-1:0]   base_new, tgt_new, el_new;
  logic [VolW-1:0]     vol_new;

  // Multiply-divide interface
  logic                md_start, md_done;
  logic [MdAW-1:0]     md_a, md_q;
  logic [MdBW-1:0]     md_b, md_d;

  logic [VIdxW-1:0]    idx;
  logic                in_range;
  logic [PitchW-1:0]   bp, tp, el, e, np16, vib;
  logic [VolW-1:0]     bv;
  logic [LenW-1:0]     len, half, lme;
  logic [2:0]          fx;
  logic                act, e_le_l;
  logic [9:0]          sv_full;
  logic [VolW-1:0]     sv;
  logic                out_free;

  assign idx      = VIdxW'(voice_q);
  assign in_range = 32'(voice_q) < NUM_VOICES;
  assign bp       = base_pitch_q[idx];
  assign tp       = target_pitch_q[idx];
  assign bv       = base_volume_q[idx];
  assign len      = note_length_q[idx];
  assign el       = elapsed_q[idx];
  assign fx       = effect_kind_q[idx];
  assign act      = active_q[idx];
  assign out_free = !out_valid_q || out_ready_i;

  // Decode the beat against the voice state
  always_comb begin
    np16      = PitchW'(np_q);
    e         = el + 1'b1;
    e_le_l    = e <= PitchW'(len);
    lme       = len - e[LenW-1:0];
    half      = (len[LenW-1:1] == '0) ? LenW'(1) : {1'b0, len[LenW-1:1]};
    vib       = bp >> VibShift;
    sv_full   = (10'(nv_q) * VOL_SCALE) >> 2;
    sv        = (sv_full > 10'(VOL_MAX)) ? VOL_MAX : sv_full[VolW-1:0];
    res_pv_d  = 1'b0;
    res_vv_d  = 1'b0;
    res_p_d   = '0;
    res_vol_d = '0;
    wr_base   = 1'b0;
    wr_tgt    = 1'b0;
    wr_vol    = 1'b0;
    wr_note   = 1'b0;
    wr_el     = 1'b0;
    wr_act    = 1'b0;
    act_new   = 1'b0;
    base_new  = np16;
    tgt_new   = np16 + (np16 >> 1);
    vol_new   = sv;
    el_new    = e;
    md_start  = 1'b0;
    md_mode_d = MD_DROP;
    md_a      = bp;
    md_b      = lme;
    md_d      = len;
    if (st_q == ST_EVAL && in_range) begin
      unique case (cmd_q)
        CMD_START: begin
          wr_act   = 1'b1;
          act_new  = 1'b1;
          wr_note  = 1'b1;
          wr_el    = 1'b1;
          el_new   = '0;
          res_vv_d = 1'b1;
          if (np_q != '0 && nv_q != '0) begin
            wr_vol    = 1'b1;
            res_vol_d = sv;
            res_pv_d  = 1'b1;
            if (eff_q == FX_SLIDE && bp != '0) begin
              wr_tgt  = 1'b1;
              tgt_new = np16;
              res_p_d = bp;
            end else begin
              wr_base = 1'b1;
              wr_tgt  = 1'b1;
              res_p_d = np16;
              if (eff_q == FX_FADE_IN) res_vol_d = '0;
            end
          end
        end
        CMD_STOP: begin
          wr_act   = 1'b1;
          act_new  = 1'b0;
          res_vv_d = 1'b1;
        end
        CMD_TICK: begin
          if (act && len != '0) begin
            wr_el = 1'b1;
            unique case (fx)
              FX_SLIDE: begin
                if (bp != tp) begin
                  res_pv_d = 1'b1;
                  res_p_d  = bp;
                  if (e >= PitchW'(half)) begin
                    wr_base  = 1'b1;
                    base_new = tp;
                    res_p_d  = tp;
                  end else begin
                    md_start  = 1'b1;
                    md_a      = (tp > bp) ? tp - bp : bp - tp;
                    md_b      = e[LenW-1:0];
                    md_d      = half;
                    md_mode_d = (tp > bp) ? MD_UP : MD_DN;
                  end
                end
              end
              FX_VIBRATO: begin
                res_pv_d = 1'b1;
                res_p_d  = e[ArpFastBit] ? bp + vib : bp - vib;
              end
              FX_DROP: begin
                if (e_le_l) begin
                  res_pv_d = 1'b1;
                  md_start = 1'b1;
                end
              end
              FX_FADE_IN, FX_FADE_OUT: begin
                if (e_le_l) begin
                  res_vv_d  = 1'b1;
                  md_start  = 1'b1;
                  md_a      = MdAW'(bv);
                  md_b      = (fx == FX_FADE_IN) ? e[LenW-1:0] : lme;
                  md_mode_d = MD_VOL;
                end
              end
              FX_ARP_FAST: begin
                res_pv_d = 1'b1;
                res_p_d  = e[ArpFastBit] ? tp : bp;
              end
              FX_ARP_SLOW: begin
                res_pv_d = 1'b1;
                res_p_d  = e[ArpSlowBit] ? tp : bp;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Update the addressed voice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        base_pitch_q[i]   <= '0;
        target_pitch_q[i] <= '0;
        base_volume_q[i]  <= '0;
        note_length_q[i]  <= '0;
        elapsed_q[i]      <= '0;
        effect_kind_q[i]  <= '0;
      end
    end else begin
      if (wr_base) base_pitch_q[idx]   <= base_new;
      if (wr_tgt)  target_pitch_q[idx] <= tgt_new;
      if (wr_vol)  base_volume_q[idx]  <= vol_new;
      if (wr_el)   elapsed_q[idx]      <= el_new;
      if (wr_act)  active_q[idx]       <= act_new;
      if (wr_note) begin
        note_length_q[idx] <= len_q;
        effect_kind_q[idx] <= eff_q;
      end
    end
  end

  // Sequence one beat: latch, evaluate, wait on the unit, hand off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      md_mode_q   <= MD_DROP;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= cmd_i;
            voice_q <= voice_i;
            np_q    <= note_pitch_i;
            nv_q    <= note_volume_i;
            eff_q   <= effect_code_i;
            len_q   <= length_ticks_i;
            st_q    <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_pv_q  <= res_pv_d;
          res_vv_q  <= res_vv_d;
          res_p_q   <= res_p_d;
          res_vol_q <= res_vol_d;
          md_mode_q <= md_mode_d;
          st_q      <= md_start ? ST_MD : ST_DONE;
        end
        ST_MD: begin
          if (md_done) begin
            unique case (md_mode_q)
              MD_DROP: res_p_q   <= md_q;
              MD_UP:   res_p_q   <= res_p_q + md_q;
              MD_DN:   res_p_q   <= res_p_q - md_q;
              MD_VOL:  res_vol_q <= md_q[VolW-1:0];
              default: ;
            endcase
            st_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_voice_q <= voice_q;
            out_pv_q    <= res_pv_q;
            out_vv_q    <= res_vv_q;
            out_p_q     <= res_p_q[NoteW-1:0];
            out_vol_q   <= res_vol_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  tvfx_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  assign in_ready_o     = (st_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_voice_o    = out_voice_q;
  assign pitch_valid_o  = out_pv_q;
  assign pitch_out_o    = out_p_q;
  assign volume_valid_o = out_vv_q;
  assign volume_out_o   = out_vol_q;

endmodule

// ===== sv/tvfx_checker.sv =====
// Port-level checks for the voice effect engine, bound to the top level.
`timescale 1ns / 1ps
module tvfx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tvfx_pkg::VoiceW-1:0] out_voice_o,
  input logic                        pitch_valid_o,
  input logic [tvfx_pkg::NoteW-1:0]  pitch_out_o,
  input logic                        volume_valid_o,
  input logic [tvfx_pkg::VolW-1:0]   volume_out_o
);
  import tvfx_pkg::*;

  // One beat in flight: ready drops right after an accept
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accepted back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_voice_o)
      && $stable(pitch_out_o) && $stable(volume_out_o)) else $error("result dropped");

  // Without a pitch write the pitch field is zero
  a_pitch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pitch_valid_o |-> pitch_out_o == '0) else $error("stray pitch");

  // Without a volume write the volume field is zero
  a_vol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !volume_valid_o |-> volume_out_o == '0) else $error("stray volume");

endmodule

bind tracker_voice_effect_engine_top tvfx_checker u_tvfx_checker (.*);

// ===== tb/tb_tracker_voice_effect_engine_top.sv =====
// Self-checking testbench for the tracker voice effect engine top level.
`timescale 1ns / 1ps
module tb_tracker_voice_effect_engine_top;
  import tvfx_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  voice;
    logic [13:0] pitch;
    logic [2:0]  vol;
    logic [2:0]  fx;
    logic [7:0]  len;
  } note_cmd_t;

  typedef struct packed {
    logic [2:0]  voice;
    logic        pv;
    logic [13:0] pitch;
    logic        vv;
    logic [6:0]  vol;
  } voice_write_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] cmd;
  logic [2:0] voice, note_volume, effect_code;
  logic [13:0] note_pitch;
  logic [7:0] length_ticks;
  logic [2:0] out_voice;
  logic pitch_valid, volume_valid;
  logic [13:0] pitch_out;
  logic [6:0] volume_out;

  tracker_voice_effect_engine_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .voice_i(voice), .note_pitch_i(note_pitch),
    .note_volume_i(note_volume), .effect_code_i(effect_code),
    .length_ticks_i(length_ticks),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_voice_o(out_voice), .pitch_valid_o(pitch_valid), .pitch_out_o(pitch_out),
    .volume_valid_o(volume_valid), .volume_out_o(volume_out)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Predictor state per voice
  logic [15:0] v_base [8], v_target [8], v_elapsed [8];
  logic [6:0]  v_bvol [8];
  logic [7:0]  v_len [8];
  logic [2:0]  v_fx [8];
  logic        v_active [8];

  note_cmd_t    pending_cmds[$];
  voice_write_t expected_writes[$];
  int errors = 0, n_accepted = 0, n_checked = 0, idle_cycles = 0;
  bit quiet_phase = 0, hold_off_req = 0, stim_done = 0, hold_issued = 0;

  function automatic voice_write_t predict_write(note_cmd_t c);
    voice_write_t w;
    logic [31:0] sv, e, b, t, half, p, vol;
    int unsigned v;
    logic pv, vv;
    v = c.voice; pv = 0; vv = 0; p = 0; vol = 0;
    if (c.cmd == CMD_START) begin
      v_active[v] = 1; v_fx[v] = c.fx; v_len[v] = c.len; v_elapsed[v] = 0;
      vv = 1;
      if (c.pitch != 0 && c.vol != 0) begin
        sv = (c.vol * 73) >> 2;
        if (sv > 127) sv = 127;
        v_bvol[v] = sv[6:0]; vol = sv; pv = 1;
        if (c.fx == FX_SLIDE && v_base[v] != 0) begin
          v_target[v] = {2'b0, c.pitch}; p = v_base[v];
        end else begin
          v_base[v] = {2'b0, c.pitch};
          v_target[v] = {2'b0, c.pitch} + ({2'b0, c.pitch} >> 1);
          p = c.pitch;
          if (c.fx == FX_FADE_IN) vol = 0;
        end
      end
    end else if (c.cmd == CMD_STOP) begin
      v_active[v] = 0; vv = 1;
    end else if (c.cmd == CMD_TICK && v_active[v] && v_len[v] != 0) begin
      e = 16'(v_elapsed[v] + 1); v_elapsed[v] = e[15:0];
      b = v_base[v]; t = v_target[v];
      case (v_fx[v])
        FX_SLIDE: if (b != t) begin
          half = v_len[v] >> 1;
          if (half == 0) half = 1;
          pv = 1;
          if (e >= half) begin v_base[v] = t[15:0]; p = t; end
          else if (t > b) p = b + ((t - b) * e) / half;
          else p = b - ((b - t) * e) / half;
        end
        FX_VIBRATO: begin
          pv = 1; p = e[3] ? 16'(b + (b >> 6)) : b - (b >> 6);
        end
        FX_DROP: if (e <= v_len[v]) begin
          pv = 1; p = (b * (v_len[v] - e)) / v_len[v];
        end
        FX_FADE_IN: if (e <= v_len[v]) begin
          vv = 1; vol = (v_bvol[v] * e) / v_len[v];
        end
        FX_FADE_OUT: if (e <= v_len[v]) begin
          vv = 1; vol = (v_bvol[v] * (v_len[v] - e)) / v_len[v];
        end
        FX_ARP_FAST: begin pv = 1; p = e[3] ? t : b; end
        FX_ARP_SLOW: begin pv = 1; p = e[4] ? t : b; end
        default: ;
      endcase
    end
    w.voice = c.voice; w.pv = pv; w.pitch = pv ? p[13:0] : '0;
    w.vv = vv; w.vol = vv ? vol[6:0] : '0;
    return w;
  endfunction

  function automatic note_cmd_t mk(logic [1:0] c, logic [2:0] v, logic [13:0] p,
                                   logic [2:0] vo, logic [2:0] f, logic [7:0] l);
    note_cmd_t n;
    n.cmd = c; n.voice = v; n.pitch = p; n.vol = vo; n.fx = f; n.len = l;
    return n;
  endfunction

  // Driver: offer queued beats with random gaps
  int gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0; cmd <= 0; voice <= 0; note_pitch <= 0;
      note_volume <= 0; effect_code <= 0; length_ticks <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_writes.push_back(predict_write(pending_cmds.pop_front()));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--; in_valid <= 0;
        end else if (pending_cmds.size() > 0) begin
          in_valid <= 1;
          {cmd, voice, note_pitch, note_volume, effect_code, length_ticks}
            <= pending_cmds[0];
          if (!quiet_phase && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
        end else in_valid <= 0;
      end
    end
  end

  // Monitor: check every output beat against the oldest prediction
  int stall = 0, hold = 0;
  voice_write_t exp_w;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (expected_writes.size() == 0) begin
          $error("unexpected output beat for voice %0d", out_voice); errors++;
        end else begin
          exp_w = expected_writes.pop_front();
          if (out_voice !== exp_w.voice) begin
            $error("out_voice exp %0d got %0d", exp_w.voice, out_voice); errors++; end
          if (pitch_valid !== exp_w.pv) begin
            $error("pitch_valid exp %0d got %0d", exp_w.pv, pitch_valid); errors++; end
          if (pitch_out !== exp_w.pitch) begin
            $error("pitch_out exp %0d got %0d", exp_w.pitch, pitch_out); errors++; end
          if (volume_valid !== exp_w.vv) begin
            $error("volume_valid exp %0d got %0d", exp_w.vv, volume_valid); errors++; end
          if (volume_out !== exp_w.vol) begin
            $error("volume_out exp %0d got %0d", exp_w.vol, volume_out); errors++; end
        end
      end
      // Long hold-off so the engine backs up into its input
      if (hold_off_req && hold == 0) begin
        hold_off_req = 0; hold = 300;
      end
      if (hold > 0) begin
        hold--; out_ready <= 0;
      end else if (stall > 0) begin
        stall--; out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!quiet_phase && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Well-formed note: start then a run of ticks on one voice, sometimes then a stop
  task automatic queue_phrase();
    logic [2:0] v, f;
    logic [7:0] l;
    int n;
    v = 3'($urandom_range(0, 7)); f = 3'($urandom_range(0, 7));
    l = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
    pending_cmds.push_back(mk(CMD_START, v, ($urandom_range(0, 9) == 0) ? 14'd0 :
      14'($urandom), ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7)), f, l));
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++)
      pending_cmds.push_back(mk(CMD_TICK, v, 14'($urandom), 3'($urandom), 3'($urandom),
                                8'($urandom)));
    if ($urandom_range(0, 3) == 0)
      pending_cmds.push_back(mk(CMD_STOP, v, 14'($urandom), 3'($urandom), 3'($urandom),
                                8'($urandom)));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      v_base[i] = 0; v_target[i] = 0; v_elapsed[i] = 0; v_bvol[i] = 0;
      v_len[i] = 0; v_fx[i] = 0; v_active[i] = 0;
    end
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // Directed: tick idle voice, every effect, rests, slide from stored pitch,
    // extremes, unknown command and stop
    pending_cmds.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_START, 1, 14'h3FFF, 7, FX_SLIDE, 255));
    pending_cmds.push_back(mk(CMD_START, 1, 100, 1, FX_SLIDE, 1));
    pending_cmds.push_back(mk(CMD_TICK, 1, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_START, 1, 0, 7, FX_SLIDE, 4));
    pending_cmds.push_back(mk(CMD_START, 2, 500, 0, FX_DROP, 5));
    pending_cmds.push_back(mk(CMD_START, 2, 800, 3, FX_DROP, 2));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(mk(CMD_TICK, 2, 0, 0, 0, 0));
    for (int f = 0; f < 8; f++) begin
      pending_cmds.push_back(mk(CMD_START, 3'(7 - f), 14'(14'h2AAA + f), 3'(f), 3'(f),
                                8'd3));
      pending_cmds.push_back(mk(CMD_TICK, 3'(7 - f), 14'h1555, 0, 0, 8'hFF));
    end
    pending_cmds.push_back(mk(2'd3, 3, 14'h3FFF, 7, 7, 255));
    pending_cmds.push_back(mk(CMD_STOP, 3, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_START, 4, 0, 0, FX_NONE, 0));
    while (pending_cmds.size() > 0 || expected_writes.size() > 0) @(posedge clk);
    // Random: mostly note phrases, some noise, one long output hold-off
    while (n_accepted < 600) begin
      if (pending_cmds.size() < 20) begin
        if ($urandom_range(0, 4) == 0)
          pending_cmds.push_back(mk(2'($urandom), 3'($urandom), 14'($urandom),
                                    3'($urandom), 3'($urandom), 8'($urandom)));
        else queue_phrase();
      end
      if (n_accepted > 200 && !hold_issued) begin
        hold_off_req = 1; hold_issued = 1;
      end
      @(posedge clk);
    end
    quiet_phase = 1;
    while (n_accepted < 760) begin
      if (pending_cmds.size() < 20) queue_phrase();
      @(posedge clk);
    end
    // Keep the beat that may be on offer, drop the rest
    while (pending_cmds.size() > 1) void'(pending_cmds.pop_back());
    while (pending_cmds.size() > 0 || in_valid || expected_writes.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d beats across all eight voices and every effect;", n_accepted);
    $display("checked %0d output beats including a long output hold-off.", n_checked);
    if (errors == 0 && expected_writes.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== tracker_voice_effect_engine_top.f =====
sv/tvfx_pkg.sv
sv/tvfx_muldiv.sv
sv/tracker_voice_effect_engine_top.sv
sv/tvfx_checker.sv
tb/tb_tracker_voice_effect_engine_top.sv
